// File: rtl/gtg_pkg.sv
// shared types, constants and reciprocal table for the grid tile geometry block
`default_nettype none
package gtg_pkg;

  localparam int DEF_MAX_WINDOWS = 64;
  localparam int RECIP_SHIFT     = 18;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TASKBAR_H  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_COUNT  = 3'd4;

  typedef struct packed {
    logic [12:0] scr_w;
    logic [12:0] scr_h;
    logic [12:0] bar_h;
    logic [7:0]  gap_pixels;
    logic [6:0]  win_cnt;
  } cfg_t;

  // grid dimensions and cell position of one request
  typedef struct packed {
    logic        ok;
    logic [3:0]  cols;
    logic [3:0]  rows;
    logic [3:0]  ri;
    logic [3:0]  ci;
    logic [3:0]  left;
    logic [14:0] numw;
    logic [14:0] numh;
  } grid_t;

  // cell sizes, last-row width still as a scaled product
  typedef struct packed {
    logic        ok;
    logic        last;
    logic [3:0]  ri;
    logic [3:0]  ci;
    logic [14:0] cw;
    logic [14:0] rh;
    logic [31:0] pwl;
    logic        wl_neg;
  } size_t;

  // ceil(2^18 / d), exact truncating division for dividends below 2^14
  function automatic logic [18:0] recip(input logic [3:0] d);
    logic [18:0] r;
    case (d)
      4'd1:    r = 19'd262144;
      4'd2:    r = 19'd131072;
      4'd3:    r = 19'd87382;
      4'd4:    r = 19'd65536;
      4'd5:    r = 19'd52429;
      4'd6:    r = 19'd43691;
      4'd7:    r = 19'd37450;
      4'd8:    r = 19'd32768;
      4'd9:    r = 19'd29128;
      4'd10:   r = 19'd26215;
      4'd11:   r = 19'd23832;
      4'd12:   r = 19'd21846;
      4'd13:   r = 19'd20165;
      4'd14:   r = 19'd18725;
      4'd15:   r = 19'd17477;
      default: r = 19'd0;
    endcase
    return r;
  endfunction

  // magnitude of a 15-bit two's complement value
  function automatic logic [13:0] mag15(input logic [14:0] v);
    logic [14:0] n;
    n = v[14] ? (15'd0 - v) : v;
    return n[13:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/gtg_grid.sv
// grid front end: column count, rows, cell position and size numerators
`default_nettype none
module gtg_grid
  import gtg_pkg::*;
#(
  parameter int MAX_WINDOWS = DEF_MAX_WINDOWS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire logic [7:0] idx,
  input  wire cfg_t       cfg,
  input  wire logic       dn_ready,
  output logic            dn_valid,
  output grid_t           dn
);

  logic        v1_r, v2_r, v3_r;
  logic        en1, en2, en3;
  logic [7:0]  idx1_r, idx2_r;
  logic [6:0]  n1_r, n2_r;
  logic [3:0]  cols1_r, cols2_r;
  logic        ok1_r, ok2_r;
  logic [31:0] prows2_r, pri2_r;
  logic [14:0] numw2_r;
  grid_t       g3_r;

  logic [6:0]  n_sat;
  logic [3:0]  cols_nxt;
  logic [3:0]  rows_c, ri_c;
  logic [7:0]  rc_prod;
  logic [12:0] gh_c;
  logic [14:0] usable_c;
  grid_t       g3_nxt;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v3_r;
  assign dn       = g3_r;

  // saturated count and ceil(sqrt(n))
  always_comb begin
    if (int'(cfg.win_cnt) > MAX_WINDOWS) n_sat = 7'(MAX_WINDOWS);
    else n_sat = cfg.win_cnt;
    cols_nxt = 4'd1;
    for (int k = 1; k < 12; k++) begin
      if (k * k < int'(n_sat)) cols_nxt = cols_nxt + 4'd1;
    end
  end

  always_comb begin
    rows_c = prows2_r[RECIP_SHIFT+3:RECIP_SHIFT];
    ri_c   = pri2_r[RECIP_SHIFT+3:RECIP_SHIFT];
    rc_prod = ri_c * cols2_r;
    gh_c = 13'({5'd0, cfg.gap_pixels} * ({9'd0, rows_c} + 13'd1));
    usable_c = {2'b0, cfg.scr_h} - {2'b0, cfg.bar_h};
    g3_nxt.ok   = ok2_r;
    g3_nxt.cols = cols2_r;
    g3_nxt.rows = rows_c;
    g3_nxt.ri   = ri_c;
    g3_nxt.ci   = 4'(idx2_r - rc_prod);
    g3_nxt.left = 4'(n2_r - 7'(rc_prod));
    g3_nxt.numw = numw2_r;
    g3_nxt.numh = usable_c - {2'b0, gh_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      idx1_r  <= idx;
      n1_r    <= n_sat;
      cols1_r <= cols_nxt;
      ok1_r   <= (n_sat != 7'd0) && (idx < {1'b0, n_sat});
    end
    if (en2) begin
      idx2_r   <= idx1_r;
      n2_r     <= n1_r;
      cols2_r  <= cols1_r;
      ok2_r    <= ok1_r;
      prows2_r <= 32'({1'b0, n1_r} + {4'd0, cols1_r} - 8'd1) * 32'(recip(cols1_r));
      pri2_r   <= 32'(idx1_r) * 32'(recip(cols1_r));
      numw2_r  <= {2'b0, cfg.scr_w}
                  - {2'b0, 13'({5'd0, cfg.gap_pixels} * ({9'd0, cols1_r} + 13'd1))};
    end
    if (en3) g3_r <= g3_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/gtg_size.sv
// cell size stages: truncating divisions of the size numerators
`default_nettype none
module gtg_size
  import gtg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire grid_t g,
  input  wire cfg_t  cfg,
  input  wire logic  dn_ready,
  output logic       dn_valid,
  output size_t      dn
);

  logic        v4_r, v5_r;
  logic        en4, en5;
  logic        ok4_r, last4_r, wneg4_r, hneg4_r;
  logic [3:0]  ri4_r, ci4_r, left4_r;
  logic [31:0] pw4_r, ph4_r;
  logic [14:0] numwl4_r;
  size_t       s5_r;
  size_t       s5_nxt;
  logic [14:0] qw, qh;

  assign en5      = !v5_r || dn_ready;
  assign en4      = !v4_r || en5;
  assign up_ready = en4;
  assign dn_valid = v5_r;
  assign dn       = s5_r;

  always_comb begin
    qw = {1'b0, pw4_r[RECIP_SHIFT+13:RECIP_SHIFT]};
    qh = {1'b0, ph4_r[RECIP_SHIFT+13:RECIP_SHIFT]};
    s5_nxt.ok     = ok4_r;
    s5_nxt.last   = last4_r;
    s5_nxt.ri     = ri4_r;
    s5_nxt.ci     = ci4_r;
    s5_nxt.cw     = wneg4_r ? (15'd0 - qw) : qw;
    s5_nxt.rh     = hneg4_r ? (15'd0 - qh) : qh;
    s5_nxt.pwl    = 32'(mag15(numwl4_r)) * 32'(recip(left4_r));
    s5_nxt.wl_neg = numwl4_r[14];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en4) v4_r <= up_valid;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      ok4_r    <= g.ok;
      last4_r  <= (g.ri == g.rows - 4'd1) && (g.left < g.cols);
      ri4_r    <= g.ri;
      ci4_r    <= g.ci;
      left4_r  <= g.left;
      wneg4_r  <= g.numw[14];
      hneg4_r  <= g.numh[14];
      pw4_r    <= 32'(mag15(g.numw)) * 32'(recip(g.cols));
      ph4_r    <= 32'(mag15(g.numh)) * 32'(recip(g.rows));
      numwl4_r <= {2'b0, cfg.scr_w}
                  - {2'b0, 13'({5'd0, cfg.gap_pixels} * ({9'd0, g.left} + 13'd1))};
    end
    if (en5) s5_r <= s5_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/gtg_place.sv
// placement stages: last-row widening, window origin and output register
`default_nettype none
module gtg_place
  import gtg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire size_t s,
  input  wire cfg_t  cfg,
  input  wire logic  dn_stall,
  output logic       dn_valid,
  output logic [16:0] x,
  output logic [16:0] y,
  output logic [16:0] w,
  output logic [16:0] h,
  output logic       ok
);

  logic        v6_r, v7_r;
  logic        en6, en7;
  logic        ok6_r;
  logic [3:0]  ri6_r, ci6_r;
  logic [16:0] cw6_r, rh6_r;
  logic [16:0] x7_r, y7_r, w7_r, h7_r;
  logic        ok7_r;
  logic [14:0] ql, cwl, cwf;
  logic [16:0] gap17, tx, ty;

  assign en7      = !v7_r || !dn_stall;
  assign en6      = !v6_r || en7;
  assign up_ready = en6;
  assign dn_valid = v7_r;
  assign x  = x7_r;
  assign y  = y7_r;
  assign w  = w7_r;
  assign h  = h7_r;
  assign ok = ok7_r;

  always_comb begin
    ql  = {1'b0, s.pwl[RECIP_SHIFT+13:RECIP_SHIFT]};
    cwl = s.wl_neg ? (15'd0 - ql) : ql;
    cwf = s.last ? cwl : s.cw;
    gap17 = {9'd0, cfg.gap_pixels};
    tx = cw6_r + gap17;
    ty = rh6_r + gap17;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en6) v6_r <= up_valid;
      if (en7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      ok6_r <= s.ok;
      ri6_r <= s.ri;
      ci6_r <= s.ci;
      cw6_r <= {{2{cwf[14]}}, cwf};
      rh6_r <= {{2{s.rh[14]}}, s.rh};
    end
    if (en7) begin
      ok7_r <= ok6_r;
      if (ok6_r) begin
        x7_r <= gap17 + 17'(17'(ci6_r) * tx);
        y7_r <= gap17 + 17'(17'(ri6_r) * ty);
        w7_r <= cw6_r;
        h7_r <= rh6_r;
      end else begin
        x7_r <= 17'd0;
        y7_r <= 17'd0;
        w7_r <= 17'd0;
        h7_r <= 17'd0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/grid_tile_geometry.sv
// grid tile geometry: top level with configuration registers and pipeline
// usage
//   in_valid/in_stall/in_window_index: one request per window index
//   out_valid/out_stall/out_win_*: rectangle of that window in the grid,
//   index_valid low and all-zero rectangle for an index beyond the count
//   cfg_we/cfg_index/cfg_data: register writes; the user, not the block,
//   keeps them to no request in flight; indexes beyond the list dropped
// pipeline and throughput
//   seven register stages lie between a taken request and its out_valid;
//   one request per cycle while out_stall is low, set by the pipelined
//   reciprocal multipliers that stand in for the column, row and size
//   divisions
// reset
//   synchronous, active low; empties the pipeline and loads the default
//   1920x1080 screen, 40 pixel taskbar, 8 pixel gap and zero windows
// stall
//   a stalled result holds; stages behind it keep filling bubbles, so
//   in_stall rises only once every stage holds a request
`default_nettype none
module grid_tile_geometry
  import gtg_pkg::*;
#(
  parameter int MAX_WINDOWS = DEF_MAX_WINDOWS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_window_index,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [16:0]         out_win_x,
  output logic signed [16:0]         out_win_y,
  output logic signed [16:0]         out_win_width,
  output logic signed [16:0]         out_win_height,
  output logic                       out_index_valid,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  up_ready;
  logic  g_valid, g_ready;
  grid_t g;
  logic  s_valid, s_ready;
  size_t s;
  logic [16:0] px, py, pw, ph;

  assign in_stall = !up_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scr_w      <= 13'd1920;
      cfg_r.scr_h      <= 13'd1080;
      cfg_r.bar_h      <= 13'd40;
      cfg_r.gap_pixels <= 8'd8;
      cfg_r.win_cnt    <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_W:  cfg_r.scr_w      <= cfg_data;
        REG_SCREEN_H:  cfg_r.scr_h      <= cfg_data;
        REG_TASKBAR_H: cfg_r.bar_h      <= cfg_data;
        REG_GAP:       cfg_r.gap_pixels <= cfg_data[7:0];
        REG_WIN_COUNT: cfg_r.win_cnt    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // stages 1-3: columns, rows, cell position, size numerators
  gtg_grid #(.MAX_WINDOWS(MAX_WINDOWS)) u_grid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (up_ready),
    .idx      (in_window_index),
    .cfg      (cfg_r),
    .dn_ready (g_ready),
    .dn_valid (g_valid),
    .dn       (g)
  );

  // stages 4-5: cell width and row height
  gtg_size u_size (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (g_valid),
    .up_ready (g_ready),
    .g        (g),
    .cfg      (cfg_r),
    .dn_ready (s_ready),
    .dn_valid (s_valid),
    .dn       (s)
  );

  // stages 6-7: short last row widening, origin, output register
  gtg_place u_place (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s_valid),
    .up_ready (s_ready),
    .s        (s),
    .cfg      (cfg_r),
    .dn_stall (out_stall),
    .dn_valid (out_valid),
    .x        (px),
    .y        (py),
    .w        (pw),
    .h        (ph),
    .ok       (out_index_valid)
  );

  assign out_win_x      = $signed(px);
  assign out_win_y      = $signed(py);
  assign out_win_width  = $signed(pw);
  assign out_win_height = $signed(ph);

endmodule
`default_nettype wire
